[rtl/dagci_pkg.sv]
//------------------------------------------------------------------------------
// dagci_pkg
// Shared types, status codes and the sequencer program for the DAG edge
// insertion core.
//------------------------------------------------------------------------------
package dagci_pkg;

	// default graph size
	localparam int NODE_COUNT_DFLT = 16;

	// request opcodes
	localparam logic OP_ADD = 1'b0;
	localparam logic OP_DEL = 1'b1;

	// result status codes
	localparam logic [2:0] STS_ADDED   = 3'd0;
	localparam logic [2:0] STS_SELF    = 3'd1;
	localparam logic [2:0] STS_DUP     = 3'd2;
	localparam logic [2:0] STS_CYCLE   = 3'd3;
	localparam logic [2:0] STS_REMOVED = 3'd4;
	localparam logic [2:0] STS_ABSENT  = 3'd5;

	// request transaction
	typedef struct packed {
		logic       operation;
		logic [3:0] source_node;
		logic [3:0] dest_node;
	} cmd_t;

	// result transaction
	typedef struct packed {
		logic [2:0] status;
		logic [6:0] edge_total;
	} rsp_t;

	// sequencer steps
	typedef enum logic [2:0] {
		STEP_IDLE,
		STEP_RD_SRC,
		STEP_RD_DST,
		STEP_CHECK,
		STEP_PICK,
		STEP_MERGE
	} step_t;

	// row read address select
	typedef enum logic [1:0] {
		RD_NONE,
		RD_SRC,
		RD_DST,
		RD_PICK
	} rd_sel_t;

	// datapath action
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LATCH,
		ACT_CHECK,
		ACT_PICK,
		ACT_MERGE
	} act_t;

	// jump condition
	typedef enum logic [2:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_BAD,
		JC_NOT_FREE,
		JC_SEARCH_END
	} jcond_t;

	// one control word
	typedef struct packed {
		rd_sel_t rd;
		act_t    act;
		jcond_t  cond;
		step_t   target;
	} ctl_t;

	// program ROM: a taken jump to idle ends the transaction
	function automatic ctl_t ucode(input step_t step);
		ctl_t w;
		case (step)
			STEP_RD_SRC: w = '{RD_SRC,  ACT_NONE,  JC_BAD,        STEP_IDLE};
			STEP_RD_DST: w = '{RD_DST,  ACT_LATCH, JC_NEVER,      STEP_IDLE};
			STEP_CHECK:  w = '{RD_NONE, ACT_CHECK, JC_NOT_FREE,   STEP_IDLE};
			STEP_PICK:   w = '{RD_PICK, ACT_PICK,  JC_SEARCH_END, STEP_IDLE};
			STEP_MERGE:  w = '{RD_NONE, ACT_MERGE, JC_ALWAYS,     STEP_PICK};
			default:     w = '{RD_NONE, ACT_NONE,  JC_NEVER,      STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

[rtl/dag_edge_insert_cycle_check_core.sv]
//------------------------------------------------------------------------------
// dag_edge_insert_cycle_check_core
// Directed acyclic graph keeper with checked edge insertion and deletion.
//------------------------------------------------------------------------------
// One request transaction is taken when start is high and busy is low; its
// single result appears for one cycle with done high, and must be taken then:
// the receiver cannot stall. A new request is accepted in the same cycle that
// the previous result is shown. Rejects for bad endpoints are decided in the
// source read step, delete and duplicate answers in the check step; an add
// that runs the reachability walk ends in a pick step, after expanding the
// rows of at most NODE_COUNT-1 nodes. The walk is bounded by the single read
// port of the adjacency RAM: each expanded node costs one row read and one
// merge step. The adjacency rows sit in a RAM with a valid flag per row, so
// the graph is empty right after reset without any clearing pass.
//------------------------------------------------------------------------------
module dag_edge_insert_cycle_check_core
	import dagci_pkg::*;
#(
	parameter int NODE_COUNT = NODE_COUNT_DFLT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	typedef logic [NODE_COUNT-1:0] row_t;

	localparam row_t ONE = row_t'(1);

	// sequencer and datapath registers
	step_t          pc_q;
	logic           op_q;
	logic [3:0]     src_q;
	logic [3:0]     dst_q;
	row_t           row_q;
	row_t           reach_q;
	row_t           visited_q;
	logic [6:0]     cnt_q;
	row_t           row_vld_q;
	logic [NW-1:0]  rd_idx_q;
	logic           done_q;
	rsp_t           rsp_q;

	// combinational signals
	ctl_t           ctl;
	logic           jump;
	logic           fin;
	logic [2:0]     fin_sts;
	logic [6:0]     cnt_nxt;
	logic [NW-1:0]  raddr;
	logic           we;
	logic [NW-1:0]  waddr;
	row_t           wdata;
	row_t           ram_rdata;
	row_t           rdata;
	row_t           frontier;
	logic [NW-1:0]  pick;
	logic [NW-1:0]  src_idx;
	logic [NW-1:0]  dst_idx;
	row_t           src_bit;
	row_t           dst_bit;
	logic           bad;
	logic           fwd_hit;
	logic           rev_hit;
	logic           src_reached;

	// adjacency row storage
	dagci_ram #(
		.WIDTH (NODE_COUNT),
		.DEPTH (NODE_COUNT)
	) u_adj (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// rows never written read as empty
	assign rdata = row_vld_q[rd_idx_q] ? ram_rdata : '0;

	// endpoint decode
	assign src_idx = NW'(src_q);
	assign dst_idx = NW'(dst_q);
	assign src_bit = ONE << src_q;
	assign dst_bit = ONE << dst_q;
	assign bad     = (32'(src_q) >= NODE_COUNT) || (32'(dst_q) >= NODE_COUNT)
		|| (src_q == dst_q);
	// row_q holds row[src], rdata holds row[dst] during the check step
	assign fwd_hit = row_q[dst_idx];
	assign rev_hit = rdata[src_idx];

	// walk frontier and lowest pending node
	assign frontier    = reach_q & ~visited_q;
	assign src_reached = reach_q[src_idx];

	always_comb begin
		pick = '0;
		for (int i = NODE_COUNT - 1; i >= 0; i--) begin
			if (frontier[i]) begin
				pick = NW'(i);
			end
		end
	end

	// control word fetch and jump decision
	always_comb begin
		ctl = ucode(pc_q);
		case (ctl.cond)
			JC_ALWAYS:     jump = 1'b1;
			JC_BAD:        jump = bad;
			JC_NOT_FREE:   jump = (op_q == OP_DEL) || fwd_hit || rev_hit;
			JC_SEARCH_END: jump = src_reached || (frontier == '0);
			default:       jump = 1'b0;
		endcase
		fin = jump && (ctl.target == STEP_IDLE);
	end

	// read address select
	always_comb begin
		case (ctl.rd)
			RD_SRC:  raddr = src_idx;
			RD_DST:  raddr = dst_idx;
			RD_PICK: raddr = pick;
			default: raddr = rd_idx_q;
		endcase
	end

	// result status, row write and edge count update
	always_comb begin
		fin_sts = STS_ABSENT;
		we      = 1'b0;
		waddr   = src_idx;
		wdata   = row_q;
		cnt_nxt = cnt_q;
		case (ctl.act)
			ACT_NONE: begin
				fin_sts = (op_q == OP_DEL) ? STS_ABSENT : STS_SELF;
			end
			ACT_CHECK: begin
				if (op_q == OP_ADD) begin
					fin_sts = STS_DUP;
				end else if (fwd_hit) begin
					fin_sts = STS_REMOVED;
					we      = 1'b1;
					wdata   = row_q & ~dst_bit;
					cnt_nxt = cnt_q - 7'd1;
				end else if (rev_hit) begin
					fin_sts = STS_REMOVED;
					we      = 1'b1;
					waddr   = dst_idx;
					wdata   = rdata & ~src_bit;
					cnt_nxt = cnt_q - 7'd1;
				end else begin
					fin_sts = STS_ABSENT;
				end
			end
			ACT_PICK: begin
				if (src_reached) begin
					fin_sts = STS_CYCLE;
				end else begin
					fin_sts = STS_ADDED;
					we      = fin;
					wdata   = row_q | dst_bit;
					cnt_nxt = fin ? cnt_q + 7'd1 : cnt_q;
				end
			end
			default: begin
				fin_sts = STS_ABSENT;
			end
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (pc_q == STEP_IDLE) begin
			if (start) begin
				pc_q <= STEP_RD_SRC;
			end
		end else if (jump) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= step_t'(pc_q + 3'd1);
		end
	end

	// graph state and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			row_vld_q <= '0;
			reach_q   <= '0;
			visited_q <= '0;
			done_q    <= 1'b0;
		end else begin
			cnt_q  <= cnt_nxt;
			done_q <= fin;
			if (we) begin
				row_vld_q[waddr] <= 1'b1;
			end
			case (ctl.act)
				ACT_CHECK: begin
					reach_q   <= dst_bit;
					visited_q <= '0;
				end
				ACT_PICK: begin
					// nothing is marked once the frontier has run dry
					visited_q <= visited_q | (frontier & (ONE << pick));
				end
				ACT_MERGE: begin
					reach_q <= reach_q | rdata;
				end
				default: begin
					reach_q <= reach_q;
				end
			endcase
		end
	end

	// request capture, row latch and result register
	always_ff @(posedge clk) begin
		rd_idx_q <= raddr;
		if (pc_q == STEP_IDLE && start) begin
			op_q  <= req.operation;
			src_q <= req.source_node;
			dst_q <= req.dest_node;
		end
		if (ctl.act == ACT_LATCH) begin
			row_q <= rdata;
		end
		if (fin) begin
			rsp_q.status     <= fin_sts;
			rsp_q.edge_total <= cnt_nxt;
		end
	end

	assign busy = (pc_q != STEP_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// a transaction ends only with its result
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("sequencer returned to idle without a result");

	// the reported total is the stored count
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.edge_total == cnt_q))
		else $error("edge total does not match stored count");

	// edge count only moves when a result is issued
	a_cnt_move: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> done)
		else $error("edge count changed without a result");

	// an accepted add grows the count by one
	a_add_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == STS_ADDED)) |-> (cnt_q == $past(cnt_q) + 7'd1))
		else $error("added edge not counted");

	// expanded nodes are always inside the reached set
	a_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(visited_q & ~reach_q) == '0)
		else $error("walk expanded a node that was not reached");

endmodule

[rtl/dagci_ram.sv]
//------------------------------------------------------------------------------
// dagci_ram
// Generic single write port, single read port RAM with registered read data.
//------------------------------------------------------------------------------
module dagci_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
